### rtl/cpu_load_frequency_governor_defines.svh
// Assertion macros shared by the governor RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CPU_LOAD_FREQUENCY_GOVERNOR_DEFINES_SVH
`define CPU_LOAD_FREQUENCY_GOVERNOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CLFG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CLFG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/clfg_pkg.sv
// Shared types, constants and helper functions of the CPU load frequency governor.
// No dependencies; every other RTL file except the assertion macro header imports this package.
`timescale 1ns / 1ps
`default_nettype none

package clfg_pkg;

  localparam int CPUS  = 16;
  localparam int FREQS = 32;

  localparam int TICK_W = 64;
  typedef logic [TICK_W-1:0] tick_t;

  localparam int CPU_IDX_W = 4;
  typedef logic [CPU_IDX_W-1:0] cpu_idx_t;
  localparam int CPU_CODES = 1 << CPU_IDX_W;

  localparam int SLOT_W = (CPUS > 1) ? $clog2(CPUS) : 1;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam int FREQ_W = 5;
  typedef logic [FREQ_W-1:0] freq_t;
  localparam freq_t FREQ_MAX = FREQ_W'(FREQS - 1);

  localparam int PCT_W = 7;
  typedef logic [PCT_W-1:0] pct_t;
  localparam pct_t PCT_FULL = PCT_W'(100);

  // Quotient of num*100/total is below 100 when num < total, so it has PCT_W bits.
  localparam int QUO_BITS = PCT_W;
  localparam int REM_W    = TICK_W + PCT_W;
  localparam int CNT_W    = $clog2(QUO_BITS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRACE_POLLS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRATEGY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NICE_AS_IDLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INDEX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INDEX    = 3'd6;

  localparam logic [1:0] STRAT_BATTERY    = 2'd0;
  localparam logic [1:0] STRAT_SMOOTH     = 2'd1;
  localparam logic [1:0] STRAT_AGGRESSIVE = 2'd2;

  localparam logic [1:0] CM_NONE = 2'd0;
  localparam logic [1:0] CM_MIN  = 2'd1;
  localparam logic [1:0] CM_MAX  = 2'd2;

  typedef logic [CPU_CODES-1:0][SLOT_W-1:0] slot_tbl_t;

  // Maps each CPU code onto a storage slot, code modulo CPUS.
  function automatic slot_tbl_t build_slot_table();
    slot_tbl_t t;
    for (int i = 0; i < CPU_CODES; i++) begin
      t[i] = SLOT_W'(i % CPUS);
    end
    return t;
  endfunction

  localparam slot_tbl_t SLOT_TABLE = build_slot_table();

  function automatic freq_t clamp_idx(logic [FREQ_W-1:0] x);
    return (x > FREQ_MAX) ? FREQ_MAX : x;
  endfunction

  typedef struct packed {
    tick_t user;
    tick_t nice;
    tick_t sys;
    tick_t intr;
    tick_t idle;
  } prev_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SUM,
    ST_BUSY,
    ST_CMP,
    ST_TOTAL,
    ST_PREP,
    ST_DIV,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic capture;
    logic diff;
    logic sum;
    logic busy;
    logic cmp;
    logic total;
    logic prep;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last_cpu;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

### rtl/clfg_tick_if.sv
// Input channel carrying one CPU's cumulative tick counters per transfer.
// Depends on clfg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface clfg_tick_if;
  import clfg_pkg::*;

  logic     valid;
  logic     ready;
  cpu_idx_t cpu_index;
  tick_t    user_ticks;
  tick_t    nice_ticks;
  tick_t    sys_ticks;
  tick_t    intr_ticks;
  tick_t    idle_ticks;
  logic     last_cpu;

  modport source (
    output valid, cpu_index, user_ticks, nice_ticks, sys_ticks, intr_ticks,
           idle_ticks, last_cpu,
    input  ready
  );

  modport sink (
    input  valid, cpu_index, user_ticks, nice_ticks, sys_ticks, intr_ticks,
           idle_ticks, last_cpu,
    output ready
  );
endinterface

`default_nettype wire

### rtl/clfg_result_if.sv
// Output channel carrying one governor decision per poll.
// Depends on clfg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface clfg_result_if;
  import clfg_pkg::*;

  logic       valid;
  logic       ready;
  pct_t       load_pct;
  logic       load_valid;
  freq_t      freq_index;
  logic       freq_changed;
  logic [1:0] clockmod_action;

  modport source (
    output valid, load_pct, load_valid, freq_index, freq_changed, clockmod_action,
    input  ready
  );

  modport sink (
    input  valid, load_pct, load_valid, freq_index, freq_changed, clockmod_action,
    output ready
  );
endinterface

`default_nettype wire

### rtl/clfg_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on clfg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface clfg_cfg_if;
  import clfg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/clfg_ctrl.sv
// Sequencer of the governor: steps one tick sample through the datapath.
// Depends on clfg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "cpu_load_frequency_governor_defines.svh"

module clfg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  clfg_pkg::sts_t sts,
  output clfg_pkg::cmd_t cmd
);
  import clfg_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] div_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt + CNT_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_BUSY;
      end
      ST_BUSY: begin
        cmd.busy   = 1'b1;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = sts.last_cpu ? ST_TOTAL : ST_IDLE;
      end
      ST_TOTAL: begin
        cmd.total  = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == CNT_W'(QUO_BITS - 1)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // The decision is held back until the output register can take it.
        if (!sts.out_full) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `CLFG_ASSERT_IMP(a_commit_free, cmd.commit, !sts.out_full, "commit into a full output register")
  `CLFG_ASSERT_IMP(a_div_bound, state == ST_DIV, div_cnt < QUO_BITS, "divide step count overran")
  `CLFG_ASSERT_NXT(a_one_item, cmd.capture, !in_ready, "new transfer taken while item in work")

endmodule

`default_nettype wire

### rtl/clfg_dpath.sv
// Datapath of the governor: per-CPU counter store, busiest-CPU tracking,
// serial load divide, watermark decision and configuration registers.
// Depends on clfg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "cpu_load_frequency_governor_defines.svh"

module clfg_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  clfg_pkg::cmd_t                  cmd,
  output clfg_pkg::sts_t                  sts,
  input  clfg_pkg::cpu_idx_t              cpu_index,
  input  clfg_pkg::tick_t                 user_ticks,
  input  clfg_pkg::tick_t                 nice_ticks,
  input  clfg_pkg::tick_t                 sys_ticks,
  input  clfg_pkg::tick_t                 intr_ticks,
  input  clfg_pkg::tick_t                 idle_ticks,
  input  logic                            last_cpu,
  input  logic                            cfg_we,
  input  logic [clfg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clfg_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output clfg_pkg::pct_t                  load_pct,
  output logic                            load_valid,
  output clfg_pkg::freq_t                 freq_index,
  output logic                            freq_changed,
  output logic [1:0]                      clockmod_action
);
  import clfg_pkg::*;

  // Configuration and governor state.
  pct_t       low_pct;
  pct_t       high_pct;
  logic [7:0] grace_polls;
  logic [1:0] strategy;
  logic       nice_as_idle;
  freq_t      min_index;
  freq_t      max_index;
  freq_t      freq_idx;
  logic [7:0] low_count;

  // Counter store; an entry not yet written reads as zero.
  prev_t           mem [CPUS];
  logic [CPUS-1:0] vld;
  prev_t           rd_entry;
  logic            rd_vld;
  slot_t           slot;

  prev_t cur;
  logic  last_q;
  prev_t p;
  tick_t du, dn, ds, dr, di;
  tick_t s1, s2, busy;
  tick_t best_busy, best_idle, best_nice;
  logic  have_best;

  tick_t            total;
  tick_t            num;
  logic             num_ovf;
  logic             zero_tot;
  logic             sat;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dv;
  pct_t             quo;

  pct_t       load_c;
  freq_t      freq_next;
  logic [7:0] low_next;
  logic [7:0] low_inc;
  logic       changed_c;
  logic [1:0] action_c;

  assign slot = SLOT_TABLE[cpu_index];
  assign sts.last_cpu = last_q;
  assign sts.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_entry  <= mem[slot];
      mem[slot] <= '{user: user_ticks, nice: nice_ticks, sys: sys_ticks,
                     intr: intr_ticks, idle: idle_ticks};
      cur       <= '{user: user_ticks, nice: nice_ticks, sys: sys_ticks,
                     intr: intr_ticks, idle: idle_ticks};
      last_q    <= last_cpu;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.capture) begin
      rd_vld    <= vld[slot];
      vld[slot] <= 1'b1;
    end
  end

  assign p = rd_vld ? rd_entry : '0;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      du <= cur.user - p.user;
      dn <= cur.nice - p.nice;
      ds <= cur.sys - p.sys;
      dr <= cur.intr - p.intr;
      di <= cur.idle - p.idle;
    end
    if (cmd.sum) begin
      s1 <= du + dn;
      s2 <= ds + dr;
    end
    if (cmd.busy) begin
      busy <= s1 + s2;
    end
  end

  // The first sample of a poll is the default; later ones win only when strictly busier.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
    end else if (cmd.cmp) begin
      have_best <= 1'b1;
    end else if (cmd.commit) begin
      have_best <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp && (!have_best || busy > best_busy)) begin
      best_busy <= busy;
      best_idle <= di;
      best_nice <= dn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.total) begin
      total          <= best_busy + best_idle;
      {num_ovf, num} <= {1'b0, best_idle} + {1'b0, (nice_as_idle ? best_nice : '0)};
    end
    if (cmd.prep) begin
      zero_tot <= (total == '0);
      sat      <= num_ovf || (num >= total);
      rem      <= REM_W'(num) * REM_W'(PCT_FULL);
      dv       <= REM_W'(total) << (QUO_BITS - 1);
      quo      <= '0;
    end
    // Restoring divide, one quotient bit per step, most significant first.
    if (cmd.div_step) begin
      if (rem >= dv) begin
        rem <= rem - dv;
        quo <= {quo[PCT_W-2:0], 1'b1};
      end else begin
        quo <= {quo[PCT_W-2:0], 1'b0};
      end
      dv <= dv >> 1;
    end
  end

  always_comb begin
    load_c    = '0;
    freq_next = freq_idx;
    low_next  = low_count;
    low_inc   = low_count;
    changed_c = 1'b0;
    action_c  = CM_NONE;
    if (!zero_tot) begin
      load_c = sat ? '0 : PCT_FULL - quo;
      if (freq_idx > min_index && load_c < low_pct) begin
        low_inc  = (low_count < grace_polls) ? low_count + 8'd1 : low_count;
        low_next = low_inc;
        if (low_inc >= grace_polls) begin
          freq_next = (strategy == STRAT_BATTERY) ? min_index : freq_idx - FREQ_W'(1);
          changed_c = 1'b1;
          if (freq_next == min_index) begin
            action_c = CM_MIN;
          end
        end
      end else begin
        low_next = '0;
        if (freq_idx < max_index && load_c > high_pct) begin
          freq_next = (strategy == STRAT_AGGRESSIVE) ? max_index : freq_idx + FREQ_W'(1);
          changed_c = 1'b1;
          if (freq_next != min_index) begin
            action_c = CM_MAX;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_pct      <= PCT_W'(40);
      high_pct     <= PCT_W'(80);
      grace_polls  <= '0;
      strategy     <= STRAT_SMOOTH;
      nice_as_idle <= 1'b0;
      min_index    <= '0;
      max_index    <= clamp_idx(FREQ_W'(31));
      freq_idx     <= '0;
      low_count    <= '0;
    end else if (cmd.commit) begin
      freq_idx  <= freq_next;
      low_count <= low_next;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_PCT:      low_pct      <= cfg_data[PCT_W-1:0];
        REG_HIGH_PCT:     high_pct     <= cfg_data[PCT_W-1:0];
        REG_GRACE_POLLS:  grace_polls  <= cfg_data;
        REG_STRATEGY:     strategy     <= cfg_data[1:0];
        REG_NICE_AS_IDLE: nice_as_idle <= cfg_data[0];
        REG_MIN_INDEX: begin
          min_index <= clamp_idx(cfg_data[FREQ_W-1:0]);
          freq_idx  <= clamp_idx(cfg_data[FREQ_W-1:0]);
        end
        REG_MAX_INDEX:    max_index    <= clamp_idx(cfg_data[FREQ_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      load_pct        <= load_c;
      load_valid      <= !zero_tot;
      freq_index      <= freq_next;
      freq_changed    <= changed_c;
      clockmod_action <= action_c;
    end
  end

  `CLFG_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid, "decision not presented after commit")
  `CLFG_ASSERT_IMP(a_load_range, out_valid, load_pct <= PCT_FULL, "load above full scale")
  `CLFG_ASSERT_IMP(a_invalid_quiet, out_valid && !load_valid, !freq_changed && clockmod_action == CM_NONE && load_pct == '0, "action on invalid load")

endmodule

`default_nettype wire

### rtl/cpu_load_frequency_governor.sv
// CPU load frequency governor. Each transfer on ticks carries one CPU's cumulative
// counters; after reset all stored counters read as zero (per-slot valid bits, no
// clearing pass). A sample without last_cpu occupies the block from its transfer to the
// next ready through the subtract, two add and compare steps of the datapath; a sample
// with last_cpu also runs the total, prepare, one-bit-per-cycle load divide and decide
// steps, and the decision waits while the result register is full. One result transfers
// per poll. Configuration writes are always ready and take effect at once, but a write
// in the cycle of a commit is dropped; write them only while no poll is in flight.
// Depends on clfg_pkg, the channel interfaces, clfg_ctrl and clfg_dpath.
`timescale 1ns / 1ps
`default_nettype none

module cpu_load_frequency_governor (
  input  logic          clk,
  input  logic          rst,
  clfg_tick_if.sink     ticks,
  clfg_result_if.source result,
  clfg_cfg_if.sink      cfg
);
  import clfg_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign ticks.ready = in_ready;
  assign cfg.ready   = 1'b1;

  clfg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ticks.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clfg_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cpu_index       (ticks.cpu_index),
    .user_ticks      (ticks.user_ticks),
    .nice_ticks      (ticks.nice_ticks),
    .sys_ticks       (ticks.sys_ticks),
    .intr_ticks      (ticks.intr_ticks),
    .idle_ticks      (ticks.idle_ticks),
    .last_cpu        (ticks.last_cpu),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .load_pct        (result.load_pct),
    .load_valid      (result.load_valid),
    .freq_index      (result.freq_index),
    .freq_changed    (result.freq_changed),
    .clockmod_action (result.clockmod_action)
  );

endmodule

`default_nettype wire
